FILE: rtl/core/jdg_pkg.sv
package jdg_pkg;

   // Field widths.
   localparam int UNIX_W = 33;
   localparam int JD_W   = 39;
   localparam int SOD_W  = 17;
   localparam int CENT_W = 43;

   localparam int ANGLE_BITS_DEFAULT = 32;

   // Pipeline: stage 0 takes the timestamp, stage 8 holds the result.
   localparam int STAGES   = 9;
   localparam int STG_DATE = 3;
   localparam int STG_LAST = STAGES - 1;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } pipe_ctl_type;

   // Day split: u / 86400 = (u >> 7) / 675, done by reciprocal and one correction.
   localparam int DAY_SHIFT       = 7;
   localparam int DAY_X_W         = UNIX_W - DAY_SHIFT;
   localparam int DAY_RECIP_W     = 27;
   localparam int DAY_RECIP_SHIFT = 36;
   localparam int DAY_PROD_W      = DAY_X_W + DAY_RECIP_W;
   localparam int DAYS_W          = 17;
   localparam int DAY_BASE_W      = UNIX_W + 1;
   localparam logic [9:0] DAY_ODD = 10'd675;
   localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
      DAY_RECIP_W'((64'd1 << DAY_RECIP_SHIFT) / 64'd675);
   localparam logic [SOD_W-1:0] SEC_PER_DAY = 17'd86400;

   // Julian date of the Unix epoch in half-seconds.
   localparam logic [JD_W-1:0] JD_EPOCH = 39'd421733520000;

   // Signed day offset n = 2 * days - 21915.
   localparam int MAG_W = 18;
   localparam logic [MAG_W:0] N_OFFSET = 19'd21915;

   // Centuries: q = floor(diff * 2^33 / 24654375), diff = 2u + 4418064000.
   localparam int DIFF_W       = 35;
   localparam int CR_W         = 44;
   localparam int CR_HALF      = 22;
   localparam int CR_SHIFT     = 35;
   localparam int CR_PROD_W    = DIFF_W + CR_HALF;
   localparam int CR_SUM_W     = CR_PROD_W + CR_HALF + 1;
   localparam int CQ_W         = 44;
   localparam int CREM_W       = 26;
   localparam logic [DIFF_W-1:0] DIFF_OFFSET = 35'd4418064000;
   localparam logic [24:0] CENT_DIV = 25'd24654375;
   localparam logic [CR_W-1:0] CENT_RECIP =
      CR_W'((128'd1 << 68) / 128'd24654375);
   localparam logic [CQ_W-1:0] CENT_BIAS = 44'd1 << 40;

   // Sidereal polynomial coefficients in units of 2^-64 turn.
   localparam logic [255:0] DAY_CENTURY_W = 256'd6311520000;
   localparam logic [63:0] K0 =
      64'((256'd2411054841 << 64) / (256'd100000 * 256'd86400));
   localparam logic [63:0] K1 =
      64'((256'd8640184812866 << 64) / (256'd1000000 * DAY_CENTURY_W));
   localparam logic [63:0] K2 =
      64'((256'd93104 << 96) / (256'd1000000 * DAY_CENTURY_W * 256'd73050));
   localparam logic [63:0] K3 =
      64'((256'd62 << 120) / (256'd10000000 * DAY_CENTURY_W * 256'd5336302500));
   localparam logic [63:0] K4 =
      64'((256'd100273790935 << 80) / (256'd100000000000 * 256'd86400));
   localparam logic [63:0] K5 =
      64'((256'd59 << 96) / (256'd1000000000000 * DAY_CENTURY_W));

   localparam int K3_W  = 38;
   localparam int M2_W  = 2 * MAG_W;
   localparam int MS_W  = MAG_W + SOD_W;
   localparam int M3_W  = 54;
   localparam int M3_H  = M3_W / 2;

endpackage

FILE: rtl/core/jdg_date.sv
module jdg_date (
   input  logic                          clock,
   input  jdg_pkg::pipe_ctl_type         ctl,
   input  logic [jdg_pkg::UNIX_W-1:0]    unix_seconds,
   output logic [jdg_pkg::SOD_W-1:0]     sod,
   output logic [jdg_pkg::MAG_W-1:0]     mag,
   output logic                          neg,
   output logic [jdg_pkg::DIFF_W-1:0]    diffp,
   output logic [jdg_pkg::JD_W-1:0]      jd
);
   import jdg_pkg::*;

   logic [UNIX_W-1:0]     u0_ff, u1_ff, u2_ff;
   logic [DAY_PROD_W-1:0] prod1_ff, prod1_in;
   logic [DAYS_W-1:0]     est2, days2_ff, days2_in;
   logic [DAY_X_W-1:0]    est_mul, rem2;
   logic [DAY_BASE_W-1:0] day_base, sod_full;
   logic [MAG_W:0]        n_val, n_abs;
   logic [SOD_W-1:0]      sod3_ff, sod3_in;
   logic [MAG_W-1:0]      mag3_ff, mag3_in;
   logic                  neg3_ff, neg3_in;
   logic [DIFF_W-1:0]     diff3_ff, diff3_in;
   logic [JD_W-1:0]       jd3_ff, jd3_in;

   assign prod1_in = DAY_PROD_W'(u0_ff[UNIX_W-1:DAY_SHIFT]) * DAY_PROD_W'(DAY_RECIP);

   // The reciprocal estimate is at most one low.
   always_comb begin
      est2     = prod1_ff[DAY_RECIP_SHIFT +: DAYS_W];
      est_mul  = DAY_X_W'(est2) * DAY_X_W'(DAY_ODD);
      rem2     = u1_ff[UNIX_W-1:DAY_SHIFT] - est_mul;
      days2_in = est2 + DAYS_W'(rem2 >= DAY_X_W'(DAY_ODD));
   end

   always_comb begin
      day_base = DAY_BASE_W'(days2_ff) * DAY_BASE_W'(SEC_PER_DAY);
      sod_full = DAY_BASE_W'(u2_ff) - day_base;
      sod3_in  = sod_full[SOD_W-1:0];
      n_val    = {1'b0, days2_ff, 1'b0} - N_OFFSET;
      neg3_in  = n_val[MAG_W];
      n_abs    = neg3_in ? ((MAG_W+1)'(0) - n_val) : n_val;
      mag3_in  = n_abs[MAG_W-1:0];
      diff3_in = {1'b0, u2_ff, 1'b0} + DIFF_OFFSET;
      jd3_in   = JD_EPOCH + JD_W'({u2_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         u0_ff <= unix_seconds;
      end
      if (ctl.load[1]) begin
         u1_ff    <= u0_ff;
         prod1_ff <= prod1_in;
      end
      if (ctl.load[2]) begin
         u2_ff    <= u1_ff;
         days2_ff <= days2_in;
      end
      if (ctl.load[STG_DATE]) begin
         sod3_ff  <= sod3_in;
         mag3_ff  <= mag3_in;
         neg3_ff  <= neg3_in;
         diff3_ff <= diff3_in;
         jd3_ff   <= jd3_in;
      end
   end

   assign sod   = sod3_ff;
   assign mag   = mag3_ff;
   assign neg   = neg3_ff;
   assign diffp = diff3_ff;
   assign jd    = jd3_ff;

endmodule

FILE: rtl/core/jdg_cent.sv
module jdg_cent (
   input  logic                        clock,
   input  jdg_pkg::pipe_ctl_type       ctl,
   input  logic [jdg_pkg::DIFF_W-1:0]  diffp,
   output logic [jdg_pkg::CENT_W-1:0]  cent
);
   import jdg_pkg::*;

   logic [CR_PROD_W-1:0] plo4_ff, phi4_ff;
   logic [CR_SUM_W-1:0]  sum5;
   logic [CQ_W-1:0]      est5_ff, est6_ff;
   logic [CREM_W-1:0]    rprod6_ff, rprod6_in, rem7;
   logic [CQ_W-1:0]      q7, qr7, half7, c7;
   logic [CENT_W-1:0]    cent7_ff;

   // Quotient estimate from two half-width partial products.
   assign sum5 = {1'b0, phi4_ff, {CR_HALF{1'b0}}} + CR_SUM_W'(plo4_ff);

   // The dividend has its low 33 bits zero, so the remainder's low bits suffice.
   assign rprod6_in = CREM_W'(est5_ff[CREM_W-1:0] * CREM_W'(CENT_DIV));

   always_comb begin
      rem7  = CREM_W'(0) - rprod6_ff;
      q7    = est6_ff + CQ_W'(rem7 >= CREM_W'(CENT_DIV));
      qr7   = q7 + CQ_W'(1);
      half7 = qr7 >> 1;
      c7    = half7 - CENT_BIAS;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         plo4_ff <= CR_PROD_W'(diffp) * CR_PROD_W'(CENT_RECIP[CR_HALF-1:0]);
         phi4_ff <= CR_PROD_W'(diffp) * CR_PROD_W'(CENT_RECIP[CR_W-1:CR_HALF]);
      end
      if (ctl.load[5]) begin
         est5_ff <= sum5[CR_SHIFT +: CQ_W];
      end
      if (ctl.load[6]) begin
         est6_ff   <= est5_ff;
         rprod6_ff <= rprod6_in;
      end
      if (ctl.load[7]) begin
         cent7_ff <= c7[CENT_W-1:0];
      end
   end

   assign cent = cent7_ff;

endmodule

FILE: rtl/core/jdg_gmst.sv
module jdg_gmst #(
   parameter int ANGLE_BITS = jdg_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  jdg_pkg::pipe_ctl_type       ctl,
   input  logic [jdg_pkg::MAG_W-1:0]   mag,
   input  logic                        neg,
   input  logic [jdg_pkg::SOD_W-1:0]   sod,
   output logic [ANGLE_BITS-1:0]       angle
);
   import jdg_pkg::*;

   localparam logic [63:0] ROUND_HALF = 64'd1 << (64 - ANGLE_BITS - 1);

   // Stage 4
   logic [M2_W-1:0]     m2_4_ff;
   logic [MS_W-1:0]     ms4_ff;
   logic [MAG_W+31:0]   p1lo4_ff;
   logic [31:0]         p1hi4_ff;
   logic [SOD_W+31:0]   p4lo4_ff, p4hi4_ff;
   logic [MAG_W-1:0]    mag4_ff;
   logic                neg4_ff;
   logic [MAG_W+31:0]   p1hi_full;
   // Stage 5
   logic [63:0]         t1_5_ff, t1_5_in, t4_5_ff;
   logic [SOD_W+64:0]   full4;
   logic [M3_W-1:0]     m3_5_ff;
   logic [M2_W+31:0]    k2lo5_ff, k2hi5_ff;
   logic [MS_W+31:0]    k5p5_ff;
   logic                neg5_ff;
   // Stage 6
   logic [63:0]         acc6_ff, t2_6_ff, t5_6_ff, t5_6_in;
   logic [M3_H+K3_W-1:0] p3lo6_ff, p3hi6_ff;
   logic                neg6_ff;
   // Stage 7
   logic [M3_W+K3_W-1:0] full3;
   logic [63:0]         acc7_ff, t3_7_ff, t3_7_in;
   // Stage 8
   logic [63:0]         total8;
   logic [ANGLE_BITS-1:0] angle8_ff;

   assign p1hi_full = (MAG_W+32)'(mag) * (MAG_W+32)'(K1[63:32]);

   // Linear term, sign applied after the magnitude product.
   always_comb begin
      t1_5_in = 64'(p1lo4_ff) + {p1hi4_ff, 32'd0};
      if (neg4_ff) begin
         t1_5_in = 64'd0 - t1_5_in;
      end
      full4 = {p4hi4_ff, 32'd0} + (SOD_W+65)'(p4lo4_ff);
   end

   always_comb begin
      t5_6_in = 64'(k5p5_ff[MS_W+31:32]);
      if (neg5_ff) begin
         t5_6_in = 64'd0 - t5_6_in;
      end
   end

   always_comb begin
      full3   = {p3hi6_ff, {M3_H{1'b0}}} + (M3_W+K3_W)'(p3lo6_ff);
      t3_7_in = 64'(full3[M3_W+K3_W-1:56]);
      if (neg6_ff) begin
         t3_7_in = 64'd0 - t3_7_in;
      end
      total8 = acc7_ff - t3_7_ff + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         m2_4_ff  <= M2_W'(mag) * M2_W'(mag);
         ms4_ff   <= MS_W'(mag) * MS_W'(sod);
         p1lo4_ff <= (MAG_W+32)'(mag) * (MAG_W+32)'(K1[31:0]);
         p1hi4_ff <= p1hi_full[31:0];
         p4lo4_ff <= (SOD_W+32)'(sod) * (SOD_W+32)'(K4[31:0]);
         p4hi4_ff <= (SOD_W+32)'(sod) * (SOD_W+32)'(K4[63:32]);
         mag4_ff  <= mag;
         neg4_ff  <= neg;
      end
      if (ctl.load[5]) begin
         t1_5_ff  <= t1_5_in;
         t4_5_ff  <= full4[79:16];
         m3_5_ff  <= M3_W'(m2_4_ff) * M3_W'(mag4_ff);
         k2lo5_ff <= (M2_W+32)'(m2_4_ff) * (M2_W+32)'(K2[31:0]);
         k2hi5_ff <= (M2_W+32)'(m2_4_ff) * (M2_W+32)'(K2[63:32]);
         k5p5_ff  <= (MS_W+32)'(ms4_ff) * (MS_W+32)'(K5[31:0]);
         neg5_ff  <= neg4_ff;
      end
      if (ctl.load[6]) begin
         acc6_ff  <= K0 + t1_5_ff + t4_5_ff;
         t2_6_ff  <= k2hi5_ff[63:0] + 64'(k2lo5_ff[M2_W+31:32]);
         t5_6_ff  <= t5_6_in;
         p3lo6_ff <= (M3_H+K3_W)'(m3_5_ff[M3_H-1:0]) * (M3_H+K3_W)'(K3[K3_W-1:0]);
         p3hi6_ff <= (M3_H+K3_W)'(m3_5_ff[M3_W-1:M3_H]) * (M3_H+K3_W)'(K3[K3_W-1:0]);
         neg6_ff  <= neg5_ff;
      end
      if (ctl.load[7]) begin
         acc7_ff <= acc6_ff + t2_6_ff + t5_6_ff;
         t3_7_ff <= t3_7_in;
      end
      if (ctl.load[8]) begin
         angle8_ff <= total8[63 -: ANGLE_BITS];
      end
   end

   assign angle = angle8_ff;

endmodule

FILE: rtl/core/unix_time_to_julian_date_and_gmst_top.sv
// Converts a UTC Unix timestamp into its Julian date, seconds of day, Julian
// centuries since J2000 and Greenwich mean sidereal time.
//
// The request channel carries one 33-bit timestamp per transfer; the response
// channel carries the four results of that timestamp per transfer. Both use
// valid and stall: a transfer happens at a rising edge with valid high and
// stall low. Results leave in the order the timestamps arrived.
//
// The datapath is a nine-stage pipeline; a result is shown on the response
// port once its request has reached stage 8. One timestamp is taken in every
// cycle while the receiver does not stall, so the throughput is one item per
// cycle. The depth is set by the chain of constant-reciprocal multiplies
// for the day split, the century quotient and the cubic sidereal polynomial.
//
// Each stage has its own valid bit. When the receiver stalls, the pipeline
// keeps filling its empty stages and only stalls the sender once every stage
// holds an item. Reset clears the valid bits; no data is lost or repeated.
module unix_time_to_julian_date_and_gmst_top #(
   parameter int ANGLE_BITS = jdg_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [jdg_pkg::UNIX_W-1:0]        req_unix_seconds,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [jdg_pkg::JD_W-1:0]          rsp_julian_date_half_seconds,
   output logic [jdg_pkg::SOD_W-1:0]         rsp_seconds_of_day,
   output logic signed [jdg_pkg::CENT_W-1:0] rsp_julian_centuries,
   output logic [ANGLE_BITS-1:0]             rsp_sidereal_angle
);
   import jdg_pkg::*;

   logic [STAGES-1:0] valid_ff, valid_in, load;
   pipe_ctl_type      ctl;

   logic [SOD_W-1:0]  sod3;
   logic [MAG_W-1:0]  mag3;
   logic              neg3;
   logic [DIFF_W-1:0] diff3;
   logic [JD_W-1:0]   jd3;
   logic [CENT_W-1:0] cent7;
   logic [ANGLE_BITS-1:0] angle8;

   // Results that are ready early ride along until the last stage.
   logic [JD_W-1:0]   jd_pipe_ff  [STG_DATE+1:STG_LAST];
   logic [SOD_W-1:0]  sod_pipe_ff [STG_DATE+1:STG_LAST];
   logic [CENT_W-1:0] cent8_ff;

   // A stage may load when it is empty or its content moves on.
   always_comb begin
      load[STG_LAST] = !valid_ff[STG_LAST] || !rsp_stall;
      for (int s = STG_LAST - 1; s >= 0; s--) begin
         load[s] = !valid_ff[s] || load[s+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int s = 1; s < STAGES; s++) begin
         if (load[s]) begin
            valid_in[s] = valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load = load;

   jdg_date u_date (
      .clock        (clock),
      .ctl          (ctl),
      .unix_seconds (req_unix_seconds),
      .sod          (sod3),
      .mag          (mag3),
      .neg          (neg3),
      .diffp        (diff3),
      .jd           (jd3)
   );

   jdg_cent u_cent (
      .clock (clock),
      .ctl   (ctl),
      .diffp (diff3),
      .cent  (cent7)
   );

   jdg_gmst #(.ANGLE_BITS(ANGLE_BITS)) u_gmst (
      .clock (clock),
      .ctl   (ctl),
      .mag   (mag3),
      .neg   (neg3),
      .sod   (sod3),
      .angle (angle8)
   );

   always_ff @(posedge clock) begin
      if (load[STG_DATE+1]) begin
         jd_pipe_ff[STG_DATE+1]  <= jd3;
         sod_pipe_ff[STG_DATE+1] <= sod3;
      end
      for (int s = STG_DATE + 2; s <= STG_LAST; s++) begin
         if (load[s]) begin
            jd_pipe_ff[s]  <= jd_pipe_ff[s-1];
            sod_pipe_ff[s] <= sod_pipe_ff[s-1];
         end
      end
      if (load[STG_LAST]) begin
         cent8_ff <= cent7;
      end
   end

   assign req_stall                    = !load[0];
   assign rsp_valid                    = valid_ff[STG_LAST];
   assign rsp_julian_date_half_seconds = jd_pipe_ff[STG_LAST];
   assign rsp_seconds_of_day           = sod_pipe_ff[STG_LAST];
   assign rsp_julian_centuries         = $signed(cent8_ff);
   assign rsp_sidereal_angle           = angle8;

endmodule

FILE: rtl/core/jdg_checker.sv
module jdg_checker #(
   parameter int ANGLE_BITS = jdg_pkg::ANGLE_BITS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [jdg_pkg::JD_W-1:0]          rsp_julian_date_half_seconds,
   input logic [jdg_pkg::SOD_W-1:0]         rsp_seconds_of_day,
   input logic signed [jdg_pkg::CENT_W-1:0] rsp_julian_centuries,
   input logic [ANGLE_BITS-1:0]             rsp_sidereal_angle
);
   import jdg_pkg::*;

   // A valid result has a proper time of day and a whole-second date.
   a_day_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_seconds_of_day < SEC_PER_DAY) && !rsp_julian_date_half_seconds[0])
      else $error("result fields out of range");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Without back pressure the block takes a request every cycle.
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_stall |-> !req_stall)
      else $error("request stalled while the receiver is free");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_julian_date_half_seconds)
         && $stable(rsp_seconds_of_day) && $stable(rsp_julian_centuries)
         && $stable(rsp_sidereal_angle))
      else $error("stalled result changed");

endmodule

bind unix_time_to_julian_date_and_gmst_top jdg_checker #(.ANGLE_BITS(ANGLE_BITS)) u_checker (.*);
